>>> rtl/lusp_pkg.sv
// lusp_pkg: shared types and constants for the scaled-pivot lu block
// no dependencies
package lusp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 4;

  typedef enum logic [12:0] {
    StLoad   = 13'b0000000000001,
    StPvRd   = 13'b0000000000010,
    StPvChk  = 13'b0000000000100,
    StSwRd   = 13'b0000000001000,
    StSwWr   = 13'b0000000010000,
    StPivRd  = 13'b0000000100000,
    StDivGo  = 13'b0000001000000,
    StDivRun = 13'b0000010000000,
    StUpdRd  = 13'b0000100000000,
    StUpdMul = 13'b0001000000000,
    StUpdWr  = 13'b0010000000000,
    StOutRd  = 13'b0100000000000,
    StOutWt  = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic start;
    logic signed [DataW-1:0] num;
    logic signed [DataW-1:0] den;
  } div_req_t;

endpackage

>>> rtl/lu_decomposition_scaled_pivot.sv
// lu_decomposition_scaled_pivot: top level, load, pivot, eliminate, stream out
// depends on lusp_pkg, lusp_div
//
// channel   | dir | fields
// s_axis    | in  | tdata[31:0] element_value
// cfg       | in  | cfg_data_i[3:0] matrix_size
// m_axis    | out | tdata row, col, lower, upper, perm, status; tlast last_cell
//
// sequence: load the elements; then per column k a pivot scan of rows k to n-1,
// a row swap when the best row is not row k, a pivot read, and per row below the
// pivot a divide plus an update of each cell right of column k; a final diagonal
// check, then the output cells are streamed out
// reset: clears control, load count, permutation and lower valid bits
// stalls: m_axis_tready low holds the current cell; s_axis_tready is low outside loading
module lu_decomposition_scaled_pivot
  import lusp_pkg::*;
#(
  parameter int unsigned MaxSize  = 8,
  parameter int unsigned FracBits = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // element_value
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_data_i,     // matrix_size
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_index[2:0] column_index[5:3] lower_value[37:6] upper_value[69:38]
  // permutation_bit[70] status[71]
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast    // last_cell
);
  localparam int unsigned IdxW  = $clog2(MaxSize);
  localparam int unsigned Cells = MaxSize * MaxSize;
  localparam int unsigned AdrW  = $clog2(Cells);
  localparam int unsigned CntW  = AdrW + 1;

  logic [DataW-1:0] umem [Cells];
  logic [DataW-1:0] lmem [Cells];
  logic [Cells-1:0] lval_q, lval_d;
  logic [IdxW-1:0]  perm_q [MaxSize];
  logic [IdxW-1:0]  perm_d [MaxSize];

  logic [SizeW-1:0] size_q;
  logic [IdxW:0]    n;
  state_e           st_q, st_d;
  logic [CntW-1:0]  lcnt_q, lcnt_d;
  logic [IdxW:0]    k_q, k_d, i_q, i_d, j_q, j_d, best_q, best_d;
  logic [DataW:0]   rmax_q, rmax_d, kmag_q, kmag_d, bnum_q, bnum_d, bden_q, bden_d;
  logic             sing_q, sing_d, ph_q, ph_d;
  logic signed [DataW-1:0] piv_q, piv_d, m_q, m_d, a_q, a_d, t_q, t_d;
  logic signed [2*DataW-1:0] prod_q, prod_d;
  logic             fin_q, fin_d, r0_fin, fin_c;

  // memory ports
  logic            ure, uwe, lre, lwe;
  logic [AdrW-1:0] ura, uwa, lra, lwa;
  logic [DataW-1:0] uwd, lwd, urd_q, lrd_q;
  logic            lrv_q;

  always_ff @(posedge clk_i) begin
    if (uwe) umem[uwa] <= uwd;
    if (ure) urd_q <= umem[ura];
    if (lwe) lmem[lwa] <= lwd;
    if (lre) begin
      lrd_q <= lmem[lra];
      lrv_q <= lval_q[lra];
    end
  end

  always_comb begin
    if (size_q < 4'd2) n = (IdxW+1)'(2);
    else if (32'(size_q) > MaxSize) n = (IdxW+1)'(MaxSize);
    else n = (IdxW+1)'(size_q);
  end

  function automatic logic [AdrW-1:0] adr(input logic [IdxW:0] r, input logic [IdxW:0] c,
                                          input logic [IdxW:0] nn);
    logic [2*IdxW+2:0] t;
    t = r * nn + c;
    return t[AdrW-1:0];
  endfunction

  function automatic logic [DataW:0] mg(input logic [DataW-1:0] v);
    return v[DataW-1] ? (DataW+1)'(-{v[DataW-1], v}) : {1'b0, v};
  endfunction

  div_req_t dreq;
  logic dq_done;
  logic signed [DataW-1:0] dq;
  lusp_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .done_o(dq_done), .quo_o(dq)
  );

  // output register
  logic ov_q, ov_d;
  logic [79:0] od_q, od_d;
  logic ol_q, ol_d;
  logic [IdxW:0] or_q, or_d, oc_q, oc_d;
  logic signed [DataW-1:0] lo;
  logic signed [2*DataW-1:0] sh;
  logic signed [2*DataW:0] diff;
  logic [2*DataW+1:0] c1, c2;

  assign s_axis_tready = (st_q == StLoad);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tlast = ol_q;

  always_comb begin
    st_d = st_q; lcnt_d = lcnt_q; k_d = k_q; i_d = i_q; j_d = j_q; best_d = best_q;
    rmax_d = rmax_q; kmag_d = kmag_q; bnum_d = bnum_q; bden_d = bden_q;
    sing_d = sing_q; ph_d = ph_q; piv_d = piv_q; m_d = m_q; a_d = a_q; t_d = t_q;
    prod_d = prod_q; lval_d = lval_q; perm_d = perm_q;
    ov_d = ov_q; od_d = od_q; ol_d = ol_q; or_d = or_q; oc_d = oc_q;
    ure = 1'b0; uwe = 1'b0; lre = 1'b0; lwe = 1'b0;
    ura = '0; uwa = '0; lra = '0; lwa = '0; uwd = '0; lwd = '0;
    dreq = '0; lo = '0; sh = '0; diff = '0; c1 = '0; c2 = '0;
    r0_fin = 1'b0; fin_c = 1'b0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      StLoad: begin
        if (s_axis_tvalid) begin
          if (32'(lcnt_q) < Cells) begin
            uwe = 1'b1; uwa = lcnt_q[AdrW-1:0]; uwd = s_axis_tdata;
          end
          lcnt_d = (32'(lcnt_q) < Cells) ? lcnt_q + 1'b1 : lcnt_q;
          if (32'(lcnt_d) >= 32'(n) * 32'(n)) begin
            lcnt_d = '0; sing_d = 1'b0; lval_d = '0; k_d = '0;
            for (int q = 0; q < MaxSize; q++) perm_d[q] = IdxW'(q);
            if (n == (IdxW+1)'(1)) st_d = StOutRd;
            else begin
              i_d = '0; j_d = '0; rmax_d = '0; st_d = StPvRd;
            end
          end
        end
      end
      StPvRd: begin
        ure = 1'b1; ura = adr(k_q + i_q, j_q, n);
        st_d = StPvChk;
      end
      StPvChk: begin
        if (mg(urd_q) > rmax_q) rmax_d = mg(urd_q);
        if (j_q == k_q) kmag_d = mg(urd_q);
        st_d = StPvRd;
        j_d = j_q + 1'b1;
        if (j_q == n - 1'b1) begin
          logic [DataW:0] nm, dn, rm;
          rm = (mg(urd_q) > rmax_q) ? mg(urd_q) : rmax_q;
          if (rm == '0) begin
            sing_d = 1'b1; nm = '0; dn = (DataW+1)'(1);
          end else begin
            nm = (j_q == k_q) ? mg(urd_q) : kmag_q; dn = rm;
          end
          c1 = nm * bden_q; c2 = bnum_q * dn;
          if (i_q == '0 || c1 > c2) begin
            best_d = k_q + i_q; bnum_d = nm; bden_d = dn;
          end
          j_d = '0; rmax_d = '0; i_d = i_q + 1'b1;
          if (k_q + i_q == n - 1'b1) begin
            j_d = '0; ph_d = 1'b0;
            st_d = ((k_q + i_q == n - 1'b1) && (best_d != k_q)) ? StSwRd : StPivRd;
          end
        end
      end
      StSwRd: begin
        ure = 1'b1; ura = adr(ph_q ? k_q : best_q, j_q, n);
        lre = 1'b1; lra = ura;
        // row k gets the saved best-row data while its old data is read out
        if (ph_q) begin
          uwe = 1'b1; uwa = ura; uwd = a_q;
          lwe = 1'b1; lwa = ura; lwd = t_q; lval_d[ura] = 1'b1;
        end
        st_d = StSwWr;
      end
      StSwWr: begin
        if (!ph_q) begin
          a_d = urd_q; t_d = lrv_q ? lrd_q : '0; ph_d = 1'b1; st_d = StSwRd;
        end else begin
          uwe = 1'b1; uwa = adr(best_q, j_q, n); uwd = urd_q;
          lwe = 1'b1; lwa = uwa; lwd = lrv_q ? lrd_q : '0; lval_d[uwa] = 1'b1;
          ph_d = 1'b0; st_d = StSwRd;
          j_d = j_q + 1'b1;
          if (j_q == n - 1'b1) begin
            perm_d[best_q[IdxW-1:0]] = perm_q[k_q[IdxW-1:0]];
            perm_d[k_q[IdxW-1:0]] = perm_q[best_q[IdxW-1:0]];
            j_d = '0; st_d = StPivRd;
          end
        end
      end
      StPivRd: begin
        if (ph_q) begin
          piv_d = urd_q; ph_d = 1'b0;
          if (urd_q == '0) begin
            sing_d = 1'b1;
            k_d = k_q + 1'b1;
            if (k_q + 1'b1 == n - 1'b1) begin
              ure = 1'b1; ura = adr(n - 1'b1, n - 1'b1, n); st_d = StOutRd;
              ph_d = 1'b0; r0_fin = 1'b1;
            end else begin
              i_d = '0; j_d = '0; rmax_d = '0; st_d = StPvRd;
            end
          end else begin
            i_d = k_q + 1'b1; st_d = StDivGo;
          end
        end else begin
          ure = 1'b1; ura = adr(k_q, k_q, n); ph_d = 1'b1;
        end
      end
      StDivGo: begin
        if (ph_q) begin
          dreq.start = 1'b1; dreq.num = urd_q; dreq.den = piv_q;
          ph_d = 1'b0; st_d = StDivRun;
        end else begin
          ure = 1'b1; ura = adr(i_q, k_q, n); ph_d = 1'b1;
        end
      end
      StDivRun: begin
        if (dq_done) begin
          m_d = dq;
          lwe = 1'b1; lwa = adr(i_q, k_q, n); lwd = dq; lval_d[lwa] = 1'b1;
          uwe = 1'b1; uwa = lwa; uwd = '0;
          j_d = k_q + 1'b1; ph_d = 1'b0; st_d = StUpdRd;
        end
      end
      StUpdRd: begin
        ure = 1'b1;
        ura = ph_q ? adr(i_q, j_q, n) : adr(k_q, j_q, n);
        if (ph_q) begin
          t_d = urd_q; st_d = StUpdMul;
        end
        ph_d = !ph_q;
      end
      StUpdMul: begin
        prod_d = t_q * m_q; a_d = urd_q; st_d = StUpdWr;
      end
      StUpdWr: begin
        sh = (prod_q[2*DataW-1] && prod_q[FracBits-1:0] != '0)
           ? (prod_q >>> FracBits) + 1 : (prod_q >>> FracBits);
        diff = (2*DataW+1)'(a_q) - (2*DataW+1)'(sh);
        uwe = 1'b1; uwa = adr(i_q, j_q, n);
        if (diff > 65'sh0_7fff_ffff) uwd = 32'h7fffffff;
        else if (diff < -65'sh0_8000_0000) uwd = 32'h80000000;
        else uwd = diff[DataW-1:0];
        j_d = j_q + 1'b1; st_d = StUpdRd;
        if (j_q == n - 1'b1) begin
          i_d = i_q + 1'b1; st_d = StDivGo;
          if (i_q == n - 1'b1) begin
            k_d = k_q + 1'b1;
            if (k_q + 1'b1 == n - 1'b1) begin
              st_d = StOutRd; r0_fin = 1'b1;
            end else begin
              i_d = '0; j_d = '0; rmax_d = '0; st_d = StPvRd;
            end
          end
        end
      end
      StOutRd: begin
        if (fin_q) begin
          // final diagonal check
          if (ph_q) begin
            if (urd_q == '0) sing_d = 1'b1;
            ph_d = 1'b0; or_d = '0; oc_d = '0; fin_c = 1'b1;
          end else begin
            ure = 1'b1; ura = adr(n - 1'b1, n - 1'b1, n); ph_d = 1'b1;
          end
        end else if (!ov_q || m_axis_tready) begin
          ure = 1'b1; ura = adr(or_q, oc_q, n);
          lre = 1'b1; lra = ura;
          st_d = StOutWt;
        end
      end
      StOutWt: begin
        if (or_q == oc_q) lo = 32'(1) <<< FracBits;
        else if (oc_q > or_q) lo = '0;
        else lo = lrv_q ? lrd_q : '0;
        ov_d = 1'b1;
        od_d = {8'd0, sing_q, (perm_q[or_q[IdxW-1:0]] == oc_q[IdxW-1:0]),
                urd_q, lo, 3'(oc_q), 3'(or_q)};
        ol_d = (or_q == n - 1'b1) && (oc_q == n - 1'b1);
        st_d = StOutRd;
        oc_d = oc_q + 1'b1;
        if (oc_q == n - 1'b1) begin
          oc_d = '0; or_d = or_q + 1'b1;
          if (or_q == n - 1'b1) st_d = StLoad;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_comb begin
    fin_d = fin_q;
    if (r0_fin) fin_d = 1'b1;
    if (fin_c) fin_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; lcnt_q <= '0; size_q <= 4'd8; sing_q <= 1'b0;
      ov_q <= 1'b0; lval_q <= '0; ph_q <= 1'b0; fin_q <= 1'b0;
      or_q <= '0; oc_q <= '0;
      for (int q = 0; q < MaxSize; q++) perm_q[q] <= IdxW'(q);
    end else begin
      st_q <= st_d; lcnt_q <= lcnt_d; sing_q <= sing_d; ov_q <= ov_d;
      lval_q <= lval_d; ph_q <= ph_d; fin_q <= fin_d; perm_q <= perm_d;
      or_q <= or_d; oc_q <= oc_d;
      if (cfg_valid_i) size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; i_q <= i_d; j_q <= j_d; best_q <= best_d;
    rmax_q <= rmax_d; kmag_q <= kmag_d; bnum_q <= bnum_d; bden_q <= bden_d;
    piv_q <= piv_d; m_q <= m_d; a_q <= a_d; t_q <= t_d; prod_q <= prod_d;
    od_q <= od_d; ol_q <= ol_d;
  end
endmodule

>>> rtl/lusp_div.sv
// lusp_div: restoring divider, one quotient bit per cycle
// depends on lusp_pkg
module lusp_div
  import lusp_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] quo_o
);
  localparam int unsigned NumW = DataW + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [DataW:0]  dsr_q, dsr_d;
  logic [NumW:0]   rem_q, rem_d, trial;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [DataW:0]  an, bn;

  always_comb begin
    an = req_i.num[DataW-1] ? (DataW+1)'(-{req_i.num[DataW-1], req_i.num})
                            : {1'b0, req_i.num};
    bn = req_i.den[DataW-1] ? (DataW+1)'(-{req_i.den[DataW-1], req_i.den})
                            : {1'b0, req_i.den};
    dvd_d = dvd_q; dsr_d = dsr_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[NumW-1:0], dvd_q[NumW-1]};
    if (req_i.start) begin
      dvd_d = {an[NumW-FracBits-1:0], {FracBits{1'b0}}};
      dsr_d = bn; rem_d = '0; quo_d = '0;
      cnt_d = CntW'(NumW); neg_d = req_i.num[DataW-1] ^ req_i.den[DataW-1];
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= (NumW+1)'(dsr_q)) begin
        rem_d = trial - (NumW+1)'(dsr_q); quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial; quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; dsr_q <= dsr_d; rem_q <= rem_d; quo_q <= quo_d;
    cnt_q <= cnt_d; neg_q <= neg_d;
  end

  logic [NumW:0] sq;
  always_comb begin
    sq = neg_q ? (NumW+1)'(-{1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > NumW'(32'h7fffffff)) quo_o = 32'sh7fffffff;
    else if (neg_q && quo_q > NumW'(33'h80000000)) quo_o = 32'sh80000000;
    else quo_o = sq[DataW-1:0];
  end
  assign done_o = done_q;
endmodule

>>> dv/tb.sv
// tb: self-checking bench for lu_decomposition_scaled_pivot, streams random and corner
// matrices at several sizes and checks every l, u and p cell against a behavioral factorizer
// depends on lusp_pkg and the rtl top level
module tb;
  import lusp_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int signed OneFx = 32'sh0001_0000;

  typedef struct {
    bit [2:0]  row;
    bit [2:0]  col;
    bit [31:0] lower;
    bit [31:0] upper;
    bit        perm;
    bit        status;
    bit        last;
  } lu_cell_t;

  class lu_scoreboard;
    bit [SizeW-1:0] size_reg = 4'd8;
    int signed      mat_u[64];
    int signed      mat_l[64];
    int unsigned    row_src[8];
    int unsigned    fill_cnt;
    bit             singular;
    lu_cell_t       cells_due[$];
    int unsigned    errors, cells_seen, runs, singular_runs;

    function int unsigned dim();
      if (size_reg < 2) return 2;
      if (size_reg > 8) return 8;
      return size_reg;
    endfunction

    function int signed sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function longint unsigned magn(int signed v);
      longint w;
      w = v;
      return (w < 0) ? -w : w;
    endfunction

    function void factor(int unsigned n);
      int unsigned    best, t;
      longint unsigned bnum, bden, rmax, num, den;
      int signed      piv, mul, tmp;
      longint         v;
      singular = 0;
      foreach (row_src[i]) row_src[i] = i;
      foreach (mat_l[i]) mat_l[i] = 0;
      for (int unsigned k = 0; k + 1 < n; k++) begin
        best = k; bnum = 0; bden = 1;
        for (int unsigned i = k; i < n; i++) begin
          rmax = 0;
          for (int unsigned j = 0; j < n; j++)
            if (magn(mat_u[i*n+j]) > rmax) rmax = magn(mat_u[i*n+j]);
          if (rmax == 0) begin
            singular = 1; num = 0; den = 1;
          end else begin
            num = magn(mat_u[i*n+k]); den = rmax;
          end
          if (i == k || num * bden > bnum * den) begin
            best = i; bnum = num; bden = den;
          end
        end
        if (best != k) begin
          for (int unsigned j = 0; j < n; j++) begin
            tmp = mat_u[best*n+j]; mat_u[best*n+j] = mat_u[k*n+j]; mat_u[k*n+j] = tmp;
            tmp = mat_l[best*n+j]; mat_l[best*n+j] = mat_l[k*n+j]; mat_l[k*n+j] = tmp;
          end
          t = row_src[best]; row_src[best] = row_src[k]; row_src[k] = t;
        end
        piv = mat_u[k*n+k];
        if (piv == 0) begin
          singular = 1;
          continue;
        end
        for (int unsigned i = k + 1; i < n; i++) begin
          v = longint'(mat_u[i*n+k]) * 65536;
          mul = sat(v / longint'(piv));
          mat_l[i*n+k] = mul;
          mat_u[i*n+k] = 0;
          for (int unsigned j = k + 1; j < n; j++) begin
            v = longint'(mul) * longint'(mat_u[k*n+j]);
            v = longint'(mat_u[i*n+j]) - v / 65536;
            mat_u[i*n+j] = sat(v);
          end
        end
      end
      if (mat_u[(n-1)*n+(n-1)] == 0) singular = 1;
    endfunction

    function void note_element(bit [31:0] value);
      int unsigned n;
      lu_cell_t c;
      n = dim();
      if (fill_cnt < 64) begin
        mat_u[fill_cnt] = value;
        fill_cnt++;
      end
      if (fill_cnt < n * n) return;
      factor(n);
      fill_cnt = 0;
      runs++;
      if (singular) singular_runs++;
      for (int unsigned r = 0; r < n; r++)
        for (int unsigned q = 0; q < n; q++) begin
          c.row = r; c.col = q;
          c.lower = (r == q) ? OneFx : (q > r) ? 0 : mat_l[r*n+q];
          c.upper = mat_u[r*n+q];
          c.perm = (row_src[r] == q);
          c.status = singular;
          c.last = (r == n - 1 && q == n - 1);
          cells_due.push_back(c);
        end
    endfunction

    function void check_cell(bit [79:0] data, bit last);
      lu_cell_t e;
      cells_seen++;
      if (cells_due.size() == 0) begin
        $error("unexpected result transfer, data %h", data);
        errors++;
        return;
      end
      e = cells_due.pop_front();
      if (data[2:0] != e.row) begin
        $error("row_index expected %0d got %0d", e.row, data[2:0]); errors++;
      end
      if (data[5:3] != e.col) begin
        $error("column_index expected %0d got %0d", e.col, data[5:3]); errors++;
      end
      if (data[37:6] != e.lower) begin
        $error("lower_value expected %h got %h", e.lower, data[37:6]); errors++;
      end
      if (data[69:38] != e.upper) begin
        $error("upper_value expected %h got %h", e.upper, data[69:38]); errors++;
      end
      if (data[70] != e.perm) begin
        $error("permutation_bit expected %0d got %0d", e.perm, data[70]); errors++;
      end
      if (data[71] != e.status) begin
        $error("status expected %0d got %0d", e.status, data[71]); errors++;
      end
      if (last != e.last) begin
        $error("last_cell expected %0d got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  lu_scoreboard lu_sb = new();
  int unsigned  cycle_cnt = 0;
  int unsigned  elems_sent = 0;
  bit           no_gaps = 0;
  bit           hold_req = 0;

  lu_decomposition_scaled_pivot DUT (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) lu_sb.check_cell(m_axis_tdata, m_axis_tlast);

  // result side backpressure
  initial begin
    int unsigned stall_left, r;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready = 0;
        repeat (2500) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 0;
      end else if (no_gaps) begin
        m_axis_tready = 1;
      end else begin
        r = $urandom_range(0, 99);
        m_axis_tready = (r < 70);
        if (r >= 70) stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  task automatic send_element(bit [31:0] value);
    int unsigned gap;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
      if (gap > 0) begin
        s_axis_tvalid = 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1;
    s_axis_tdata = value;
    do @(posedge clk_i); while (!s_axis_tready);
    lu_sb.note_element(value);
    elems_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (lu_sb.cells_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_size(bit [3:0] value);
    drain();
    cfg_valid_i = 1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    lu_sb.size_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  function automatic bit [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    if (r < 85) return $urandom();
    if (r < 90) return 32'h7fff_ffff;
    if (r < 95) return 32'h8000_0000;
    return 0;
  endfunction

  task automatic send_matrix(int unsigned n);
    bit [31:0]   m[64];
    int unsigned kind, a, b;
    foreach (m[i]) m[i] = pick_value();
    kind = $urandom_range(0, 9);
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 1);
    // zero row, dependent rows, zero leading column
    if (kind == 0) for (int unsigned j = 0; j < n; j++) m[a*n+j] = 0;
    if (kind == 1 && a != b) for (int unsigned j = 0; j < n; j++) m[a*n+j] = m[b*n+j];
    if (kind == 2) for (int unsigned i = 0; i < n; i++) m[i*n] = 0;
    for (int unsigned i = 0; i < n * n; i++) send_element(m[i]);
  endtask

  initial begin
    bit [3:0]    sizes[12] = '{4'd2, 4'd0, 4'd3, 4'd1, 4'd15, 4'd4, 4'd8, 4'd5, 4'd3,
                               4'd6, 4'd7, 4'd9};
    bit [31:0]   corner[20] = '{
      32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0,             // needs a row swap
      32'h0, 32'h0, 32'h0, 32'h0,                             // all-zero matrix
      32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
      32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000, // rank one
      32'h0, 32'h0005_0000, 32'h0, 32'h0003_0000};            // zero pivot column
    int unsigned ph, n, mats;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    write_size(4'd2);
    foreach (corner[i]) send_element(corner[i]);

    ph = 0;
    while (elems_sent < 320) begin
      write_size(sizes[ph % 12]);
      n = lu_sb.dim();
      no_gaps = (ph % 5 == 3);
      if (ph == 2) hold_req = 1;
      mats = (n * n >= 32) ? 1 : 32 / (n * n);
      for (int unsigned k = 0; k < mats; k++) begin
        send_matrix(n);
        if (ph == 5 && k == 0) drain();
      end
      ph++;
    end
    no_gaps = 0;
    drain();
    repeat (50) @(negedge clk_i);

    if (lu_sb.cells_due.size() != 0) begin
      $error("%0d expected cells never arrived", lu_sb.cells_due.size());
      lu_sb.errors++;
    end
    $display("fed %0d elements over %0d size phases, including out-of-range size settings",
             elems_sent, ph + 1);
    $display("factored %0d matrices (%0d singular), checked %0d cells",
             lu_sb.runs, lu_sb.singular_runs, lu_sb.cells_seen);
    if (lu_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
